// File: src/jzq_pkg.sv
`timescale 1ns / 1ps

package jzq_pkg;

    localparam int BLOCK_ENTRIES     = 64;
    localparam int IDX_W             = 6;
    localparam int COEF_W            = 16;
    localparam int QUANT_W           = 8;
    localparam int DIV_BITS_PER_STEP = 8;
    localparam int DIV_STEPS         = COEF_W / DIV_BITS_PER_STEP;
    localparam int DIV_CNT_W         = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

    localparam logic [IDX_W-1:0]     IDX_LAST     = IDX_W'(BLOCK_ENTRIES - 1);
    localparam logic [DIV_CNT_W-1:0] DIV_CNT_LAST = DIV_CNT_W'(DIV_STEPS - 1);

    localparam logic REQ_QUANT = 1'b0;
    localparam logic REQ_COEF  = 1'b1;

    // Raster position of each zigzag position.
    localparam logic [IDX_W-1:0] SCAN_ORDER [0:BLOCK_ENTRIES-1] = '{
         0,  1,  8, 16,  9,  2,  3, 10, 17, 24, 32, 25, 18, 11,  4,  5,
        12, 19, 26, 33, 40, 48, 41, 34, 27, 20, 13,  6,  7, 14, 21, 28,
        35, 42, 49, 56, 57, 50, 43, 36, 29, 22, 15, 23, 30, 37, 44, 51,
        58, 59, 52, 45, 38, 31, 39, 46, 53, 60, 61, 54, 47, 55, 62, 63
    };

    function automatic logic [IDX_W-1:0] scan_pos(input logic [IDX_W-1:0] zz);
        return SCAN_ORDER[zz];
    endfunction

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_LOAD,
        S_DIV,
        S_OUT
    } t_state;

    typedef struct packed {
        logic store_quant;
        logic store_coef;
        logic rd_issue;
        logic div_load;
        logic div_step;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic fill_last;
        logic emit_last;
        logic div_last;
        logic out_free;
    } t_dp_status;

endpackage

// File: src/jzq_if.sv
`timescale 1ns / 1ps

interface jzq_in_if import jzq_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic                       req_type;
    logic signed [COEF_W-1:0]   coefficient;
    logic        [IDX_W-1:0]    quant_index;
    logic        [QUANT_W-1:0]  quant_value;

    modport source (output valid, req_type, coefficient, quant_index, quant_value,
                    input ready);
    modport sink   (input valid, req_type, coefficient, quant_index, quant_value,
                    output ready);
endinterface

interface jzq_out_if import jzq_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic        [IDX_W-1:0]    zigzag_index;
    logic signed [COEF_W-1:0]   quantized_value;
    logic                       last;

    modport source (output valid, zigzag_index, quantized_value, last, input ready);
    modport sink   (input valid, zigzag_index, quantized_value, last, output ready);
endinterface

// File: src/jzq_div.sv
`timescale 1ns / 1ps

module jzq_div import jzq_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_load,
    input  logic                      i_step,
    input  logic signed [COEF_W-1:0]  i_dividend,
    input  logic        [QUANT_W-1:0] i_divisor,
    output logic signed [COEF_W-1:0]  o_quotient,
    output logic                      o_last_step
);

    logic [COEF_W-1:0]    r_quo, n_quo;
    logic [QUANT_W-1:0]   r_rem, n_rem;
    logic [QUANT_W-1:0]   r_div;
    logic                 r_neg;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [QUANT_W:0]     trial;
    logic [COEF_W-1:0]    mag;

    assign mag = i_dividend[COEF_W-1] ? COEF_W'(-i_dividend) : COEF_W'(i_dividend);

    // Restoring division on magnitudes, several quotient bits per step.
    always_comb begin
        n_quo = r_quo;
        n_rem = r_rem;
        trial = '0;
        for (int i = 0; i < DIV_BITS_PER_STEP; i++) begin
            trial = {n_rem, n_quo[COEF_W-1]};
            n_quo = {n_quo[COEF_W-2:0], 1'b0};
            if (trial >= {1'b0, r_div}) begin
                trial    = trial - {1'b0, r_div};
                n_quo[0] = 1'b1;
            end
            n_rem = trial[QUANT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= '0;
        end else if (i_step) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_quo <= mag;
            r_rem <= '0;
            r_div <= i_divisor;
            r_neg <= i_dividend[COEF_W-1];
        end else if (i_step) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_quotient  = r_neg ? COEF_W'(-r_quo) : r_quo;
    assign o_last_step = (r_cnt == DIV_CNT_LAST);

endmodule

// File: src/jzq_datapath.sv
`timescale 1ns / 1ps

module jzq_datapath import jzq_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_dp_cmd                   i_cmd,
    output t_dp_status                o_status,
    input  logic signed [COEF_W-1:0]  i_coefficient,
    input  logic        [IDX_W-1:0]   i_quant_index,
    input  logic        [QUANT_W-1:0] i_quant_value,
    input  logic                      i_out_ready,
    output logic                      o_out_valid,
    output logic        [IDX_W-1:0]   o_zigzag_index,
    output logic signed [COEF_W-1:0]  o_quantized_value,
    output logic                      o_last
);

    logic signed [COEF_W-1:0]  r_coef_mem  [0:BLOCK_ENTRIES-1];
    logic        [QUANT_W-1:0] r_quant_mem [0:BLOCK_ENTRIES-1];
    logic [BLOCK_ENTRIES-1:0]  r_quant_vld;

    logic [IDX_W-1:0]          r_fill;
    logic [IDX_W-1:0]          r_emit;
    logic signed [COEF_W-1:0]  r_rd_coef;
    logic        [QUANT_W-1:0] r_rd_quant;
    logic                      r_rd_qvld;
    logic        [QUANT_W-1:0] divisor;

    logic                      r_out_valid;
    logic        [IDX_W-1:0]   r_out_idx;
    logic signed [COEF_W-1:0]  r_out_val;
    logic                      r_out_last;

    logic signed [COEF_W-1:0]  quotient;
    logic                      div_last;

    // Coefficient store: written in raster order, read in zigzag order.
    always_ff @(posedge i_clk) begin
        if (i_cmd.store_coef) begin
            r_coef_mem[r_fill] <= i_coefficient;
        end
        if (i_cmd.rd_issue) begin
            r_rd_coef <= r_coef_mem[scan_pos(r_emit)];
        end
    end

    // A loaded zero is kept as one, so the divisor is never zero.
    always_ff @(posedge i_clk) begin
        if (i_cmd.store_quant) begin
            r_quant_mem[i_quant_index] <= (i_quant_value == '0) ? QUANT_W'(1) : i_quant_value;
        end
        if (i_cmd.rd_issue) begin
            r_rd_quant <= r_quant_mem[r_emit];
        end
    end

    // Entries not loaded since reset read as one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quant_vld <= '0;
            r_rd_qvld   <= 1'b0;
        end else begin
            if (i_cmd.store_quant) begin
                r_quant_vld[i_quant_index] <= 1'b1;
            end
            if (i_cmd.rd_issue) begin
                r_rd_qvld <= r_quant_vld[r_emit];
            end
        end
    end

    assign divisor = r_rd_qvld ? r_rd_quant : QUANT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_emit <= '0;
        end else begin
            if (i_cmd.store_coef) begin
                r_fill <= r_fill + 1'b1;
            end
            if (i_cmd.out_load) begin
                r_emit <= r_emit + 1'b1;
            end
        end
    end

    jzq_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (i_cmd.div_load),
        .i_step      (i_cmd.div_step),
        .i_dividend  (r_rd_coef),
        .i_divisor   (divisor),
        .o_quotient  (quotient),
        .o_last_step (div_last)
    );

    // Output register: holds a finished beat until it is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_idx  <= r_emit;
            r_out_val  <= quotient;
            r_out_last <= (r_emit == IDX_LAST);
        end
    end

    assign o_status.fill_last = (r_fill == IDX_LAST);
    assign o_status.emit_last = (r_emit == IDX_LAST);
    assign o_status.div_last  = div_last;
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid       = r_out_valid;
    assign o_zigzag_index    = r_out_idx;
    assign o_quantized_value = r_out_val;
    assign o_last            = r_out_last;

endmodule

// File: src/jzq_ctrl.sv
`timescale 1ns / 1ps

module jzq_ctrl import jzq_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_req_type,
    input  t_dp_status i_status,
    output logic       o_in_ready,
    output t_dp_cmd    o_cmd
);

    t_state r_state, n_state;
    logic   accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        accept     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                accept     = i_in_valid;
                if (accept && (i_req_type == REQ_QUANT)) begin
                    o_cmd.store_quant = 1'b1;
                end
                if (accept && (i_req_type == REQ_COEF)) begin
                    o_cmd.store_coef = 1'b1;
                    // The beat that completes the block starts the scan.
                    if (i_status.fill_last) begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                o_cmd.rd_issue = 1'b1;
                n_state        = S_LOAD;
            end
            S_LOAD: begin
                o_cmd.div_load = 1'b1;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = i_status.emit_last ? S_IDLE : S_READ;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: src/jpeg_zigzag_quantizer.sv
`timescale 1ns / 1ps
// The 64th coefficient beat of a block starts its scan. Input: one beat per cycle while a
// block fills. The 64 results then leave one at a time (read, divider load, two 8-bit
// divider steps, output, which waits while the output register is full and not taken),
// all on the shared divider. No input is taken during the scan.
// Reset (synchronous, active low) empties the block and sets every quantizer entry to one.
module jpeg_zigzag_quantizer import jzq_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    jzq_in_if.sink      i_in,
    jzq_out_if.source   o_out
);

    t_dp_cmd    cmd;
    t_dp_status status;
    logic       in_ready;

    jzq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_req_type (i_in.req_type),
        .i_status   (status),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    jzq_datapath u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_coefficient     (i_in.coefficient),
        .i_quant_index     (i_in.quant_index),
        .i_quant_value     (i_in.quant_value),
        .i_out_ready       (o_out.ready),
        .o_out_valid       (o_out.valid),
        .o_zigzag_index    (o_out.zigzag_index),
        .o_quantized_value (o_out.quantized_value),
        .o_last            (o_out.last)
    );

    assign i_in.ready = in_ready;

endmodule
